// ----- hdl/swsfr_pkg.sv -----
// ----------------------------------------------------------------------------
// Single-wire sensor frame receiver package
// Shared types, codes and constants of the single-wire sensor frame receiver.
// ----------------------------------------------------------------------------
package swsfr_pkg;

  localparam int unsigned TimerW     = 16;
  localparam int unsigned LimitW     = 10;
  localparam int unsigned BitCountW  = 6;
  localparam int unsigned FrameBits  = 40;
  localparam int unsigned CfgIndexW  = 8;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned TenthsW    = 12;

  localparam logic [TimerW-1:0] TimerMax         = '1;
  localparam logic [TimerW-1:0] StartLowReset    = 16'd20000;
  localparam logic [LimitW-1:0] RespTimeoutReset = 10'd100;
  localparam logic [LimitW-1:0] BitTimeoutReset  = 10'd150;
  localparam logic [LimitW-1:0] OneThreshReset   = 10'd40;

  typedef enum logic {
    KIND_TICK  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE       = 3'd0,
    PH_START      = 3'd1,
    PH_RESP_HIGH  = 3'd2,
    PH_RESP_LOW   = 3'd3,
    PH_RESP_HIGH2 = 3'd4,
    PH_BIT_LOW    = 3'd5,
    PH_BIT_HIGH   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    ERR_NONE          = 3'd0,
    ERR_NO_RESPONSE   = 3'd1,
    ERR_RESP_LOW_TO   = 3'd2,
    ERR_RESP_HIGH_TO  = 3'd3,
    ERR_BIT_LOW_TO    = 3'd4,
    ERR_BIT_HIGH_TO   = 3'd5,
    ERR_CHECKSUM      = 3'd6
  } err_e;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_START_LOW     = 8'd0,
    CFG_RESP_TIMEOUT  = 8'd1,
    CFG_BIT_TIMEOUT   = 8'd2,
    CFG_ONE_THRESHOLD = 8'd3
  } cfg_idx_e;

  typedef struct packed {
    logic kind;
    logic line_level;
  } in_item_t;

  typedef struct packed {
    logic               drive_low;
    logic               done_res;
    logic               success;
    logic [2:0]         error_code;
    logic [5:0]         error_bit;
    logic [TenthsW-1:0] humidity_tenths;
    logic [TenthsW-1:0] temperature_tenths;
  } out_item_t;

  typedef struct packed {
    logic [TimerW-1:0] start_low_ticks;
    logic [LimitW-1:0] response_timeout;
    logic [LimitW-1:0] bit_timeout;
    logic [LimitW-1:0] one_threshold;
  } cfg_t;

endpackage

// ----- hdl/single_wire_sensor_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// Single-wire sensor frame receiver
// Reads a temperature and humidity frame from a single-wire sensor.
// ----------------------------------------------------------------------------
// Each input transaction is either a one-microsecond tick carrying the sampled
// line level or a start request, and each produces exactly one result
// transaction. The block takes one transaction per cycle unless the input is
// stalled; a transaction is held in the input register, and as it leaves, the
// sensor state advances and its result is captured in the output register. A
// stalled result holds the output register and backs up the input register.
// The configuration port is always ready.
module single_wire_sensor_frame_receiver
  import swsfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t      cfg;
  out_item_t res;
  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_data_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;
  logic      out_block, s1_adv, in_acc;

  assign out_block  = out_valid_q && out_stall_i;
  assign s1_adv     = s1_valid_q && !out_block;
  assign in_stall_o = s1_valid_q && out_block;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  swsfr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  swsfr_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .item_i (s1_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_block) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_data_q <= in_data_i;
    end
    if (s1_adv) begin
      out_data_q <= res;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("Advanced transaction did not reach the output register.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.success) |->
      (out_data_o.done_res && out_data_o.error_code == ERR_NONE))
    else $error("Successful result carries an error or no done flag.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.error_code != ERR_NONE) |->
      (out_data_o.done_res && !out_data_o.success))
    else $error("Error result without done flag or with success.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> !out_data_o.drive_low)
    else $error("Line still driven low on the result that ends a reading.");
`endif

endmodule

// ----- hdl/swsfr_cfg.sv -----
// ----------------------------------------------------------------------------
// Single-wire sensor frame receiver configuration registers
// Holds the start pulse length, the timeout limits and the one-bit threshold.
// ----------------------------------------------------------------------------
module swsfr_cfg
  import swsfr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgIndexW-1:0] cfg_index_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  output cfg_t                 cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START_LOW:     cfg_d.start_low_ticks  = cfg_data_i[TimerW-1:0];
        CFG_RESP_TIMEOUT:  cfg_d.response_timeout = cfg_data_i[LimitW-1:0];
        CFG_BIT_TIMEOUT:   cfg_d.bit_timeout      = cfg_data_i[LimitW-1:0];
        CFG_ONE_THRESHOLD: cfg_d.one_threshold    = cfg_data_i[LimitW-1:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks  <= StartLowReset;
      cfg_q.response_timeout <= RespTimeoutReset;
      cfg_q.bit_timeout      <= BitTimeoutReset;
      cfg_q.one_threshold    <= OneThreshReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ----- hdl/swsfr_core.sv -----
// ----------------------------------------------------------------------------
// Single-wire sensor frame receiver core
// Phase state machine, phase timer, bit counter and frame shifter, with the
// result of each transaction computed from the current state.
// ----------------------------------------------------------------------------
module swsfr_core
  import swsfr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  output out_item_t res_o
);

  phase_e                phase_q, phase_d;
  logic [TimerW-1:0]     timer_q, timer_d;
  logic [BitCountW-1:0]  count_q, count_d;
  logic [FrameBits-1:0]  frame_q, frame_d;

  logic [TimerW-1:0]     timer_inc;
  logic [BitCountW-1:0]  count_inc;
  logic [FrameBits-1:0]  frame_new;
  logic                  awaited;
  logic [7:0]            b0, b1, b2, b3, b4, sum;

  assign timer_inc = (timer_q == TimerMax) ? timer_q : timer_q + 1'b1;
  assign count_inc = count_q + 1'b1;
  assign awaited   = (phase_q != PH_RESP_LOW);
  assign frame_new = {frame_q[FrameBits-2:0],
                      (timer_q > TimerW'(cfg_i.one_threshold))};
  assign b0  = frame_new[39:32];
  assign b1  = frame_new[31:24];
  assign b2  = frame_new[23:16];
  assign b3  = frame_new[15:8];
  assign b4  = frame_new[7:0];
  assign sum = b0 + b1 + b2 + b3;

  always_comb begin
    phase_d = phase_q;
    timer_d = timer_q;
    count_d = count_q;
    frame_d = frame_q;
    res_o   = '0;
    if (item_i.kind == KIND_START) begin
      if (phase_q == PH_IDLE) begin
        phase_d = PH_START;
        timer_d = '0;
        count_d = '0;
        frame_d = '0;
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          phase_d = PH_IDLE;
        end
        PH_START: begin
          timer_d = timer_inc;
          if (timer_inc >= cfg_i.start_low_ticks) begin
            phase_d = PH_RESP_HIGH;
            timer_d = '0;
          end
        end
        PH_RESP_HIGH, PH_RESP_LOW, PH_RESP_HIGH2: begin
          if (item_i.line_level == awaited) begin
            timer_d = timer_inc;
            if (timer_inc > TimerW'(cfg_i.response_timeout)) begin
              phase_d        = PH_IDLE;
              timer_d        = '0;
              res_o.done_res = 1'b1;
              case (phase_q)
                PH_RESP_HIGH: res_o.error_code = ERR_NO_RESPONSE;
                PH_RESP_LOW:  res_o.error_code = ERR_RESP_LOW_TO;
                default:      res_o.error_code = ERR_RESP_HIGH_TO;
              endcase
            end
          end else begin
            timer_d = '0;
            case (phase_q)
              PH_RESP_HIGH: phase_d = PH_RESP_LOW;
              PH_RESP_LOW:  phase_d = PH_RESP_HIGH2;
              default:      phase_d = PH_BIT_LOW;
            endcase
          end
        end
        PH_BIT_LOW: begin
          if (!item_i.line_level) begin
            timer_d = timer_inc;
            if (timer_inc > TimerW'(cfg_i.bit_timeout)) begin
              phase_d          = PH_IDLE;
              timer_d          = '0;
              res_o.done_res   = 1'b1;
              res_o.error_code = ERR_BIT_LOW_TO;
              res_o.error_bit  = count_q;
            end
          end else begin
            phase_d = PH_BIT_HIGH;
            timer_d = '0;
          end
        end
        PH_BIT_HIGH: begin
          if (item_i.line_level) begin
            timer_d = timer_inc;
            if (timer_inc > TimerW'(cfg_i.bit_timeout)) begin
              phase_d          = PH_IDLE;
              timer_d          = '0;
              res_o.done_res   = 1'b1;
              res_o.error_code = ERR_BIT_HIGH_TO;
              res_o.error_bit  = count_q;
            end
          end else begin
            frame_d = frame_new;
            count_d = count_inc;
            timer_d = '0;
            if (count_inc >= BitCountW'(FrameBits)) begin
              phase_d        = PH_IDLE;
              res_o.done_res = 1'b1;
              if (sum != b4) begin
                res_o.error_code = ERR_CHECKSUM;
              end else begin
                res_o.success            = 1'b1;
                res_o.humidity_tenths    = {4'b0, b0} * TenthsW'(10) + {4'b0, b1};
                res_o.temperature_tenths = {4'b0, b2} * TenthsW'(10) + {4'b0, b3};
              end
            end else begin
              phase_d = PH_BIT_LOW;
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
    res_o.drive_low = (phase_d == PH_START);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      timer_q <= '0;
      count_q <= '0;
      frame_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      timer_q <= timer_d;
      count_q <= count_d;
      frame_q <= frame_d;
    end
  end

endmodule
